// ----- rtl/wsjq_pkg.sv -----
// ----------------------------------------------------------------------------
// wsjq_pkg
// Shared sizes, operation and status codes for the work-stealing job queues.
// ----------------------------------------------------------------------------
package wsjq_pkg;

  // Queue geometry
  localparam int NUM_WORKERS = 8;
  localparam int QUEUE_DEPTH = 32;
  localparam int TAG_BITS    = 16;

  // Derived widths
  localparam int W_BITS     = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_BITS   = CNT_BITS + 1;
  localparam int STORE_SIZE = NUM_WORKERS * QUEUE_DEPTH;
  localparam int ADDR_BITS  = $clog2(STORE_SIZE);
  localparam int PEND_BITS  = $clog2(STORE_SIZE + 1);

  // Fixed field widths on the channels
  localparam int OP_W      = 1;
  localparam int WORKER_W  = 3;
  localparam int JOB_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int QUEUE_W   = 3;
  localparam int PENDING_W = 9;

  // Request operations
  localparam logic [OP_W-1:0] OP_SUBMIT = 1'b0;
  localparam logic [OP_W-1:0] OP_FETCH  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Decision taken when a request is accepted
  typedef struct packed {
    status_t           status;
    logic [W_BITS-1:0] queue;
    logic              stolen;
    logic              take;
  } dec_t;

endpackage

// ----- rtl/wsjq_req_if.sv -----
// ----------------------------------------------------------------------------
// wsjq_req_if
// Request channel: submit or fetch, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsjq_req_if;
  import wsjq_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic                from_worker;
  logic [WORKER_W-1:0] worker;
  logic [JOB_W-1:0]    job_tag;

  modport source (output valid, op, from_worker, worker, job_tag, input ready);
  modport sink   (input valid, op, from_worker, worker, job_tag, output ready);
endinterface

// ----- rtl/wsjq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// wsjq_rsp_if
// Result channel: one result per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsjq_rsp_if;
  import wsjq_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [JOB_W-1:0]     job_out;
  logic [QUEUE_W-1:0]   queue_used;
  logic                 stolen;
  logic [PENDING_W-1:0] pending_total;

  modport source (output valid, status, job_out, queue_used, stolen, pending_total,
                  input ready);
  modport sink   (input valid, status, job_out, queue_used, stolen, pending_total,
                  output ready);
endinterface

// ----- rtl/wsjq_ram.sv -----
// ----------------------------------------------------------------------------
// wsjq_ram
// Single-port synchronous RAM with registered read data and read enable.
// ----------------------------------------------------------------------------
module wsjq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read port, hold data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/work_stealing_job_queues.sv -----
// ----------------------------------------------------------------------------
// work_stealing_job_queues
// One bounded deque of job tags per worker, with owner fetch from the front
// and stealing from the back of other queues.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries submit and fetch requests; out_rsp returns exactly one
//   result per request, in request order. Both use valid/ready; a transfer
//   happens when both are high at a rising clock edge.
//   All tags live in one single-port RAM (workers x depth entries). Queue
//   heads, counts, the round-robin pointer and the pending total sit in
//   flip-flops and are decided on and updated in the cycle a request is taken.
//   A submit writes the RAM in that cycle; a fetch reads it there and the
//   read data is held in the RAM's registered read port.
//   Each request is taken in S_IDLE; its result is loaded into the output
//   register in S_RESP, once that register is free.
//   A new request is taken only after the previous result has been loaded
//   (decide/access in S_IDLE, then result in S_RESP).
//   Reset (rst_n low, synchronous) empties every queue and clears the
//   pointer and total; the tag RAM is not cleared and needs no sweep.
//   If out_rsp stalls, the pending result is held in the output register;
//   one more request is still taken and its result waits until the output
//   register frees up, after which in_req.ready returns.
// ----------------------------------------------------------------------------
module work_stealing_job_queues (
  input  logic        clk,
  input  logic        rst_n,
  wsjq_req_if.sink    in_req,
  wsjq_rsp_if.source  out_rsp
);
  import wsjq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  state_t                  state_r;
  logic [PTR_BITS-1:0]     head_r  [NUM_WORKERS];
  logic [CNT_BITS-1:0]     count_r [NUM_WORKERS];
  logic [W_BITS-1:0]       rr_r;
  logic [PEND_BITS-1:0]    pending_r;
  dec_t                    dec_r;
  dec_t                    dec_nxt;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [JOB_W-1:0]        out_job_r;
  logic [QUEUE_W-1:0]      out_queue_r;
  logic                    out_stolen_r;
  logic [PENDING_W-1:0]    out_pending_r;

  logic                    accept;
  logic                    is_sub;
  logic [W_BITS-1:0]       me;
  logic                    own_hit;
  logic                    steal_found;
  logic [W_BITS-1:0]       steal_q;
  logic [W_BITS-1:0]       sel_q;
  logic [CNT_BITS-1:0]     sel_cnt;
  logic [CNT_BITS-1:0]     offset;
  logic [SUM_BITS-1:0]     slot_sum;
  logic [PTR_BITS-1:0]     slot;
  logic [ADDR_BITS-1:0]    addr;
  logic                    full;
  logic                    take;
  logic                    wr_en;
  logic                    rd_en;
  logic [TAG_BITS-1:0]     tag_in;
  logic [TAG_BITS-1:0]     tag_rd;

  assign accept        = in_req.valid && in_req.ready;
  assign in_req.ready  = (state_r == S_IDLE);
  assign is_sub        = (in_req.op == OP_SUBMIT);
  assign me            = W_BITS'(32'(in_req.worker) % NUM_WORKERS);
  assign own_hit       = in_req.from_worker && (count_r[me] != '0);
  assign tag_in        = TAG_BITS'(in_req.job_tag);

  // Find the lowest-numbered non-empty queue other than the requester's own
  always_comb begin
    steal_found = 1'b0;
    steal_q     = '0;
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      if ((count_r[i] != '0) && !(in_req.from_worker && (W_BITS'(i) == me))) begin
        steal_found = 1'b1;
        steal_q     = W_BITS'(i);
      end
    end
  end

  // Pick the target queue and the slot inside it
  always_comb begin
    if (is_sub) begin
      sel_q = in_req.from_worker ? me : rr_r;
    end else begin
      sel_q = own_hit ? me : steal_q;
    end
    sel_cnt = count_r[sel_q];
    full    = (sel_cnt == CNT_BITS'(QUEUE_DEPTH));
    take    = !is_sub && (own_hit || steal_found);

    if (is_sub) begin
      offset = sel_cnt;
    end else if (own_hit) begin
      offset = '0;
    end else begin
      offset = sel_cnt - CNT_BITS'(1);
    end

    slot_sum = SUM_BITS'(head_r[sel_q]) + SUM_BITS'(offset);
    if (slot_sum >= SUM_BITS'(QUEUE_DEPTH)) begin
      slot = PTR_BITS'(slot_sum - SUM_BITS'(QUEUE_DEPTH));
    end else begin
      slot = PTR_BITS'(slot_sum);
    end
    addr = ADDR_BITS'(sel_q) * ADDR_BITS'(QUEUE_DEPTH) + ADDR_BITS'(slot);

    wr_en = accept && is_sub && !full;
    rd_en = accept && take;
  end

  // Result decision for the request being taken
  always_comb begin
    dec_nxt.queue  = (is_sub || take) ? sel_q : '0;
    dec_nxt.stolen = take && !own_hit;
    dec_nxt.take   = take;
    if (is_sub) begin
      dec_nxt.status = full ? ST_FULL : ST_OK;
    end else begin
      dec_nxt.status = take ? ST_OK : ST_EMPTY;
    end
  end

  // Tag store
  wsjq_ram #(
    .DEPTH (STORE_SIZE),
    .WIDTH (TAG_BITS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .re    (rd_en),
    .addr  (addr),
    .wdata (tag_in),
    .rdata (tag_rd)
  );

  // Update queue pointers, round-robin target and pending total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORKERS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
      rr_r      <= '0;
      pending_r <= '0;
    end else if (accept) begin
      if (is_sub && !in_req.from_worker) begin
        rr_r <= (rr_r == W_BITS'(NUM_WORKERS - 1)) ? '0 : rr_r + W_BITS'(1);
      end
      if (wr_en) begin
        count_r[sel_q] <= sel_cnt + CNT_BITS'(1);
        pending_r      <= pending_r + PEND_BITS'(1);
      end
      if (take) begin
        count_r[sel_q] <= sel_cnt - CNT_BITS'(1);
        pending_r      <= pending_r - PEND_BITS'(1);
        if (own_hit) begin
          head_r[me] <= (head_r[me] == PTR_BITS'(QUEUE_DEPTH - 1)) ?
                        '0 : head_r[me] + PTR_BITS'(1);
        end
      end
    end
  end

  // Sequence each request and drive the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          // Drop the result once it has been transferred
          if (out_rsp.ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            dec_r   <= dec_nxt;
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_rsp.ready) begin
            out_valid_r   <= 1'b1;
            out_status_r  <= dec_r.status;
            out_job_r     <= dec_r.take ? JOB_W'(tag_rd) : '0;
            out_queue_r   <= QUEUE_W'(dec_r.queue);
            out_stolen_r  <= dec_r.stolen;
            out_pending_r <= PENDING_W'(pending_r);
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.job_out       = out_job_r;
  assign out_rsp.queue_used    = out_queue_r;
  assign out_rsp.stolen        = out_stolen_r;
  assign out_rsp.pending_total = out_pending_r;

endmodule

// ----- rtl/wsjq_chk.sv -----
// ----------------------------------------------------------------------------
// wsjq_chk
// Port-level checks on the job queues, bound to the top level.
// ----------------------------------------------------------------------------
module wsjq_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [wsjq_pkg::STATUS_W-1:0]  out_status,
  input logic [wsjq_pkg::JOB_W-1:0]     out_job_out,
  input logic [wsjq_pkg::QUEUE_W-1:0]   out_queue_used,
  input logic                           out_stolen,
  input logic [wsjq_pkg::PENDING_W-1:0] out_pending_total
);
  import wsjq_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_job_out) && $stable(out_pending_total))
    else $error("stalled result changed");

  // One request at a time: ready drops after a request transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in flight");

  // An empty fetch means nothing is pending anywhere
  a_empty_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
      (out_pending_total == '0) && (out_queue_used == '0) && (out_job_out == '0))
    else $error("empty fetch with jobs pending");

  // A rejected submit hands out no job
  a_full_submit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_job_out == '0) && !out_stolen)
    else $error("rejected submit reports a job");

  // Only a successful fetch can be a steal
  a_steal_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stolen |-> (out_status == ST_OK))
    else $error("steal flagged on a failed request");

endmodule

bind work_stealing_job_queues wsjq_chk u_wsjq_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_job_out       (out_rsp.job_out),
  .out_queue_used    (out_rsp.queue_used),
  .out_stolen        (out_rsp.stolen),
  .out_pending_total (out_rsp.pending_total)
);

// ----- tb/work_stealing_job_queues_test.sv -----
// ----------------------------------------------------------------------------
// work_stealing_job_queues_test
// Self-checking bench for the work-stealing job queues. A directed list of
// requests covers the edge cases (empty fetch, owner take, steal, external
// round-robin submit, full queue); then phased random traffic runs, checked
// against an in-bench scheduler model, with random bursts, gaps and stalls.
// ----------------------------------------------------------------------------
module work_stealing_job_queues_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsjq_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 15;
  localparam int PHASE_ITEMS  = 100;
  localparam int TAIL_CYCLES  = 4;

  // One result as the block reports it
  typedef struct packed {
    status_t              status;
    logic [JOB_W-1:0]     job;
    logic [QUEUE_W-1:0]   queue;
    logic                 stolen;
    logic [PENDING_W-1:0] pending;
  } sched_result_t;

  // One line of the directed list; want is used only when typed is set
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic                from_worker;
    logic [WORKER_W-1:0] worker;
    logic [JOB_W-1:0]    tag;
    logic [7:0]          reps;
    logic                typed;
    sched_result_t       want;
  } req_row_t;

  localparam sched_result_t FROM_MODEL = '0;

  logic clk = 1'b0;
  logic rst_n;

  wsjq_req_if req_ch ();
  wsjq_rsp_if rsp_ch ();

  work_stealing_job_queues dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_rsp (rsp_ch.source)
  );

  always #5 clk = ~clk;

  // Directed requests, walked in order right after reset
  req_row_t directed_rows [14] = '{
    '{OP_FETCH,  1'b0, 3'd0, 16'h0000, 8'd1,  1'b1, '{ST_EMPTY, 16'h0000, 3'd0, 1'b0, 9'd0}},
    '{OP_FETCH,  1'b1, 3'd7, 16'hFFFF, 8'd1,  1'b1, '{ST_EMPTY, 16'h0000, 3'd0, 1'b0, 9'd0}},
    '{OP_SUBMIT, 1'b1, 3'd0, 16'hFFFF, 8'd1,  1'b1, '{ST_OK,    16'h0000, 3'd0, 1'b0, 9'd1}},
    '{OP_SUBMIT, 1'b0, 3'd6, 16'h0000, 8'd1,  1'b1, '{ST_OK,    16'h0000, 3'd0, 1'b0, 9'd2}},
    '{OP_SUBMIT, 1'b1, 3'd7, 16'h8001, 8'd1,  1'b1, '{ST_OK,    16'h0000, 3'd7, 1'b0, 9'd3}},
    '{OP_FETCH,  1'b1, 3'd7, 16'h0000, 8'd1,  1'b1, '{ST_OK,    16'h8001, 3'd7, 1'b0, 9'd2}},
    '{OP_FETCH,  1'b1, 3'd3, 16'h0000, 8'd1,  1'b1, '{ST_OK,    16'h0000, 3'd0, 1'b1, 9'd1}},
    '{OP_FETCH,  1'b0, 3'd5, 16'h0000, 8'd1,  1'b1, '{ST_OK,    16'hFFFF, 3'd0, 1'b1, 9'd0}},
    '{OP_SUBMIT, 1'b1, 3'd5, 16'h1234, 8'd32, 1'b0, FROM_MODEL},
    '{OP_SUBMIT, 1'b1, 3'd5, 16'hABCD, 8'd1,  1'b1, '{ST_FULL,  16'h0000, 3'd5, 1'b0, 9'd32}},
    '{OP_SUBMIT, 1'b0, 3'd0, 16'h5555, 8'd4,  1'b0, FROM_MODEL},
    '{OP_SUBMIT, 1'b0, 3'd2, 16'h6666, 8'd1,  1'b1, '{ST_FULL,  16'h0000, 3'd5, 1'b0, 9'd36}},
    '{OP_FETCH,  1'b1, 3'd5, 16'h0000, 8'd1,  1'b1, '{ST_OK,    16'h1234, 3'd5, 1'b0, 9'd35}},
    '{OP_FETCH,  1'b1, 3'd2, 16'h0000, 8'd3,  1'b0, FROM_MODEL}
  };

  // Scheduler state mirrored in the bench
  logic [JOB_W-1:0] tag_ram [NUM_WORKERS][QUEUE_DEPTH];
  int unsigned      q_head  [NUM_WORKERS];
  int unsigned      q_count [NUM_WORKERS];
  int unsigned      rr_target;
  int unsigned      jobs_waiting;

  sched_result_t awaited_results [$];

  int error_count;
  int burst_left;
  int n_submit, n_fetch, n_full, n_empty, n_own, n_steal;
  int idle_cycles;

  // Decide one request and advance the mirrored queues
  function automatic sched_result_t schedule_request(logic [OP_W-1:0] op, logic fw,
                                                     logic [WORKER_W-1:0] w,
                                                     logic [JOB_W-1:0] tag);
    sched_result_t r;
    int unsigned   me;
    int unsigned   q;
    bit            found;
    r        = '0;
    r.status = ST_EMPTY;
    me       = w % NUM_WORKERS;
    found    = 1'b0;
    if (op == OP_SUBMIT) begin
      if (fw) begin
        q = me;
      end else begin
        q         = rr_target;
        rr_target = (rr_target + 1) % NUM_WORKERS;
      end
      r.queue = QUEUE_W'(q);
      if (q_count[q] >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        tag_ram[q][(q_head[q] + q_count[q]) % QUEUE_DEPTH] = tag;
        q_count[q]++;
        jobs_waiting++;
        r.status = ST_OK;
      end
    end else if (fw && q_count[me] != 0) begin
      // owner takes from its own front
      r.job      = tag_ram[me][q_head[me]];
      q_head[me] = (q_head[me] + 1) % QUEUE_DEPTH;
      q_count[me]--;
      jobs_waiting--;
      r.status = ST_OK;
      r.queue  = QUEUE_W'(me);
    end else begin
      // steal from the back of the lowest other non-empty queue
      for (q = 0; q < NUM_WORKERS; q++) begin
        if (!found && !(fw && q == me) && q_count[q] != 0) begin
          r.job    = tag_ram[q][(q_head[q] + q_count[q] - 1) % QUEUE_DEPTH];
          q_count[q]--;
          jobs_waiting--;
          r.status = ST_OK;
          r.queue  = QUEUE_W'(q);
          r.stolen = 1'b1;
          found    = 1'b1;
        end
      end
    end
    r.pending = PENDING_W'(jobs_waiting);
    return r;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      error_count++;
    end
  endfunction

  // Issue one request in the current burst and record what it should return
  task automatic send_request(input logic [OP_W-1:0] op, input logic fw,
                              input logic [WORKER_W-1:0] w, input logic [JOB_W-1:0] tag,
                              input logic typed, input sched_result_t want);
    sched_result_t predicted;
    int            gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    req_ch.valid       <= 1'b1;
    req_ch.op          <= op;
    req_ch.from_worker <= fw;
    req_ch.worker      <= w;
    req_ch.job_tag     <= tag;
    do @(posedge clk); while (!req_ch.ready);
    predicted = schedule_request(op, fw, w, tag);
    awaited_results.insert(awaited_results.size(), typed ? want : predicted);
    if (op == OP_SUBMIT) n_submit++;
    else                 n_fetch++;
    if (predicted.status == ST_FULL)  n_full++;
    if (predicted.status == ST_EMPTY) n_empty++;
    if (op == OP_FETCH && predicted.status == ST_OK) begin
      if (predicted.stolen) n_steal++;
      else                  n_own++;
    end
  endtask

  // Lower valid and hold until every issued request has been answered
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: status %0h job %0h queue %0h", $time,
                 rsp_ch.status, rsp_ch.job_out, rsp_ch.queue_used);
        error_count++;
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        check_field("status",        want.status,  rsp_ch.status);
        check_field("job_out",       want.job,     rsp_ch.job_out);
        check_field("queue_used",    want.queue,   rsp_ch.queue_used);
        check_field("stolen",        want.stolen,  rsp_ch.stolen);
        check_field("pending_total", want.pending, rsp_ch.pending_total);
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result stalls: switch to a new random stall pattern after each random span
  initial begin : rsp_stall_pattern
    int mode;
    int span;
    int tick;
    rsp_ch.ready <= 1'b1;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        tick++;
        case (mode)
          0: begin
            rsp_ch.ready <= 1'b1;
          end
          1: begin
            rsp_ch.ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            rsp_ch.ready <= ($urandom_range(0, 7) != 0);
          end
          3: begin
            rsp_ch.ready <= ((tick % 8) >= 3);
          end
          default: begin
            rsp_ch.ready <= ($urandom_range(0, 15) == 0);
          end
        endcase
      end
    end
  end

  // Reset, directed list, phased random traffic, then wrap up
  initial begin : stimulus
    int                  sub_pct;
    int                  ext_pct;
    logic [WORKER_W-1:0] focus;
    logic [OP_W-1:0]     op;
    logic                fw;
    logic [WORKER_W-1:0] w;
    error_count  = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    rr_target    = 0;
    jobs_waiting = 0;
    n_submit = 0; n_fetch = 0; n_full = 0; n_empty = 0; n_own = 0; n_steal = 0;
    foreach (q_head[i]) begin
      q_head[i]  = 0;
      q_count[i] = 0;
    end
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.op          <= OP_SUBMIT;
    req_ch.from_worker <= 1'b0;
    req_ch.worker      <= '0;
    req_ch.job_tag     <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      repeat (directed_rows[i].reps) begin
        send_request(directed_rows[i].op, directed_rows[i].from_worker,
                     directed_rows[i].worker, directed_rows[i].tag,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Each phase leans toward filling, mixes evenly or leans toward draining, often around one worker
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case ($urandom_range(0, 2))
        0:       sub_pct = 85;
        1:       sub_pct = 50;
        default: sub_pct = 15;
      endcase
      ext_pct = $urandom_range(10, 50);
      focus   = WORKER_W'($urandom_range(0, NUM_WORKERS - 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = ($urandom_range(0, 99) < sub_pct) ? OP_SUBMIT : OP_FETCH;
        fw = ($urandom_range(0, 99) >= ext_pct);
        w  = ($urandom_range(0, 1) != 0) ? focus : WORKER_W'($urandom_range(0, 7));
        send_request(op, fw, w, JOB_W'($urandom_range(0, 65535)), 1'b0, FROM_MODEL);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d submits and %0d fetches through directed and random phases",
             n_submit, n_fetch);
    $display("saw %0d full rejects, %0d empty fetches, %0d owner takes, %0d steals",
             n_full, n_empty, n_own, n_steal);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
